@@ rtl/rrqs_pkg.sv @@
// shared constants of the round robin quantum scheduler: state codes and stream field layout
package rrqs_pkg;

    localparam int ST_BITS = 2;
    localparam logic [ST_BITS-1:0] ST_IDLE = 2'd0;
    localparam logic [ST_BITS-1:0] ST_SCAN = 2'd1;
    localparam logic [ST_BITS-1:0] ST_RUN  = 2'd2;
    localparam logic [ST_BITS-1:0] ST_LOAD = 2'd3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic CFG_QUANTUM = 1'b0;
    localparam logic CFG_PCOUNT  = 1'b1;

    localparam int IN_BITS  = 48;
    localparam int OUT_BITS = 136;
    localparam int OUT_USED = 131;

endpackage

@@ rtl/rrqs_ram.sv @@
// generic single port write, single port read ram with registered read data
module rrqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/round_robin_quantum_scheduler.sv @@
// top level of the round robin quantum scheduler
//
// Round robin process scheduler with a time quantum, one tick per stream transaction.
// A transaction with tuser 0 loads a process slot (id, arrival, burst) and restarts the
// run; tuser 1 advances time by one tick. Every transaction returns exactly one result.
// Slot records live in one ram with a registered read; started and "remaining reloaded"
// flags live in flip-flops so a restart clears them together. A load writes its record
// into the ram when accepted and returns its result from the load state. A tick that
// continues an active slice goes straight to the run state. A tick that needs a new
// dispatch scans the slots in use through the ram read port, one slot per cycle,
// pipelined, stopping at the first ready process. The next transaction is taken while
// a result still waits in the output register.
module round_robin_quantum_scheduler #(
    parameter int MAX_PROCS = 16,
    parameter int TIME_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    // input items
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // slot[3:0], proc_id[11:4], arrival[27:12], burst[43:28], zero pad
    input  logic [rrqs_pkg::IN_BITS-1:0]  s_axis_tdata,
    // op[0]
    input  logic                          s_axis_tuser,
    // results
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // run_id[7:0], ran[8], finished[9], finished_id[17:10], finish_time[33:18],
    // turnaround[49:34], waiting[65:50], response[81:66], all_done[82],
    // dispatch_count[98:83], busy_ticks[114:99], time_now[130:115], zero pad
    output logic [rrqs_pkg::OUT_BITS-1:0] m_axis_tdata
);

    localparam int SW = $clog2(MAX_PROCS);
    localparam int NW = $clog2(MAX_PROCS + 1);
    localparam int TW = TIME_BITS;
    localparam int WX = (TW > 16) ? TW : 16;
    // ram record: id, arrival, burst, remaining, response
    localparam int EW = 8 + TW + 16 + 16 + TW;

    // configuration
    logic [15:0] r_quantum;
    logic [4:0]  r_pcount;

    // control state
    logic [rrqs_pkg::ST_BITS-1:0] r_state;
    logic [TW-1:0]        r_time;
    logic [SW-1:0]        r_last;
    logic [15:0]          r_slice;
    logic [SW-1:0]        r_slot;
    logic [4:0]           r_done_cnt;
    logic [15:0]          r_switch;
    logic [15:0]          r_busy;
    logic [MAX_PROCS-1:0] r_started;
    logic [MAX_PROCS-1:0] r_remv;

    // cached record of the running slot
    logic [7:0]    r_e_id;
    logic [TW-1:0] r_e_arr;
    logic [15:0]   r_e_burst;
    logic [15:0]   r_e_rem;
    logic [TW-1:0] r_e_resp;

    // scan pipeline
    logic [SW-1:0] r_iss_j;
    logic [NW-1:0] r_iss_k;
    logic [NW-1:0] r_chk_k;
    logic          r_pv;
    logic [SW-1:0] r_pslot;

    // output register
    logic                          r_ov;
    logic [rrqs_pkg::OUT_BITS-1:0] r_out;

    // input fields
    logic          in_op;
    logic [3:0]    in_slot;
    logic [7:0]    in_id;
    logic [15:0]   in_arr;
    logic [15:0]   in_burst;
    logic          in_acc;

    assign in_op    = s_axis_tuser;
    assign in_slot  = s_axis_tdata[3:0];
    assign in_id    = s_axis_tdata[11:4];
    assign in_arr   = s_axis_tdata[27:12];
    assign in_burst = s_axis_tdata[43:28];

    assign s_axis_tready = (r_state == rrqs_pkg::ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;

    // slots in use, saturated at the slot count
    logic [NW-1:0] n_use;
    assign n_use = (32'(r_pcount) > MAX_PROCS) ? NW'(MAX_PROCS) : NW'(r_pcount);

    // first slot of a scan: after the last dispatched, wrapping at the count
    logic [SW-1:0] scan_start;
    assign scan_start = (32'(r_last) + 1 >= 32'(n_use)) ? '0 : SW'(32'(r_last) + 1);

    logic [SW-1:0] iss_next;
    assign iss_next = (32'(r_iss_j) + 1 >= 32'(n_use)) ? '0 : SW'(32'(r_iss_j) + 1);

    // ram
    logic          ram_we;
    logic [SW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [EW-1:0] ram_rdata;

    rrqs_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_PROCS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_iss_j),
        .o_rdata (ram_rdata)
    );

    // record read during the scan
    logic [7:0]    d_id;
    logic [TW-1:0] d_arr;
    logic [15:0]   d_burst;
    logic [15:0]   d_rem;
    logic [TW-1:0] d_resp;
    logic          d_hit;

    assign {d_id, d_arr, d_burst} = ram_rdata[EW-1 -: 8 + TW + 16];
    // a slot not touched since restart still has its whole burst left
    assign d_rem  = r_remv[r_pslot] ? ram_rdata[TW +: 16] : d_burst;
    assign d_resp = ram_rdata[TW-1:0];
    assign d_hit  = r_pv && (d_arr <= r_time) && (d_rem != 16'd0);

    logic [15:0] q_eff;
    assign q_eff = (r_quantum == 16'd0) ? 16'd1 : r_quantum;

    // tick arithmetic on the running slot
    logic          ran;
    logic          out_free;
    logic          ov_set;
    logic [TW-1:0] time_n;
    logic [15:0]   rem_n;
    logic          fin;
    logic [4:0]    done_n;
    logic [15:0]   busy_n;
    logic [TW-1:0] tat;
    logic [WX-1:0] wait_v;
    logic          slot_ok;

    assign out_free = !r_ov || m_axis_tready;
    // a result is written into the output register this cycle
    assign ov_set   = (r_state == rrqs_pkg::ST_RUN || r_state == rrqs_pkg::ST_LOAD) && out_free;
    assign ran      = (r_slice != 16'd0);
    assign time_n   = (r_time != '1) ? r_time + 1'b1 : r_time;
    assign rem_n    = r_e_rem - 16'd1;
    assign fin      = ran && (rem_n == 16'd0);
    assign done_n   = (fin && r_done_cnt != 5'd31) ? r_done_cnt + 5'd1 : r_done_cnt;
    assign busy_n   = (ran && r_busy != 16'hFFFF) ? r_busy + 16'd1 : r_busy;
    assign tat      = time_n - r_e_arr;
    assign wait_v   = (WX'(tat) > WX'(r_e_burst)) ? WX'(tat) - WX'(r_e_burst) : '0;
    assign slot_ok  = (32'(in_slot) < MAX_PROCS);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_slot;
        ram_wdata = {r_e_id, r_e_arr, r_e_burst, rem_n, r_e_resp};
        if (in_acc && in_op == rrqs_pkg::OP_LOAD) begin
            ram_we    = slot_ok;
            ram_waddr = SW'(in_slot);
            ram_wdata = {in_id, TW'(in_arr), in_burst, 16'd0, TW'(0)};
        end else if (r_state == rrqs_pkg::ST_RUN && out_free && ran) begin
            ram_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum  <= 16'd4;
            r_pcount   <= 5'd16;
            r_state    <= rrqs_pkg::ST_IDLE;
            r_time     <= '0;
            r_last     <= SW'(MAX_PROCS - 1);
            r_slice    <= '0;
            r_slot     <= '0;
            r_done_cnt <= '0;
            r_switch   <= '0;
            r_busy     <= '0;
            r_started  <= '0;
            r_remv     <= '0;
            r_pv       <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    rrqs_pkg::CFG_QUANTUM: r_quantum <= i_cfg_data;
                    rrqs_pkg::CFG_PCOUNT:  r_pcount  <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (ov_set) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                rrqs_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        if (in_op == rrqs_pkg::OP_LOAD) begin
                            // restart the run
                            r_time     <= '0;
                            r_last     <= SW'(MAX_PROCS - 1);
                            r_slice    <= '0;
                            r_slot     <= '0;
                            r_done_cnt <= '0;
                            r_switch   <= '0;
                            r_busy     <= '0;
                            r_started  <= '0;
                            r_remv     <= '0;
                            r_state    <= rrqs_pkg::ST_LOAD;
                        end else if (r_slice != 16'd0 || n_use == '0) begin
                            r_state <= rrqs_pkg::ST_RUN;
                        end else begin
                            r_iss_j <= scan_start;
                            r_iss_k <= '0;
                            r_chk_k <= '0;
                            r_pv    <= 1'b0;
                            r_state <= rrqs_pkg::ST_SCAN;
                        end
                    end
                end

                rrqs_pkg::ST_SCAN: begin
                    if (d_hit) begin
                        // dispatch the slot just checked
                        r_slot    <= r_pslot;
                        r_last    <= r_pslot;
                        r_e_id    <= d_id;
                        r_e_arr   <= d_arr;
                        r_e_burst <= d_burst;
                        r_e_rem   <= d_rem;
                        r_e_resp  <= r_started[r_pslot] ? d_resp : r_time - d_arr;
                        r_started[r_pslot] <= 1'b1;
                        if (r_switch != 16'hFFFF) begin
                            r_switch <= r_switch + 16'd1;
                        end
                        r_slice <= (d_rem < q_eff) ? d_rem : q_eff;
                        r_pv    <= 1'b0;
                        r_state <= rrqs_pkg::ST_RUN;
                    end else begin
                        if (r_pv) begin
                            r_chk_k <= r_chk_k + 1'b1;
                        end
                        if (r_pv && r_chk_k + 1'b1 == n_use) begin
                            // nothing ready this tick
                            r_pv    <= 1'b0;
                            r_state <= rrqs_pkg::ST_RUN;
                        end else if (r_iss_k != n_use) begin
                            r_pv    <= 1'b1;
                            r_pslot <= r_iss_j;
                            r_iss_j <= iss_next;
                            r_iss_k <= r_iss_k + 1'b1;
                        end else begin
                            r_pv <= 1'b0;
                        end
                    end
                end

                rrqs_pkg::ST_RUN: begin
                    if (out_free) begin
                        r_time     <= time_n;
                        r_busy     <= busy_n;
                        r_done_cnt <= done_n;
                        if (ran) begin
                            r_e_rem        <= rem_n;
                            r_remv[r_slot] <= 1'b1;
                            r_slice        <= fin ? 16'd0 : r_slice - 16'd1;
                        end
                        r_out <= {
                            (rrqs_pkg::OUT_BITS - rrqs_pkg::OUT_USED)'(0),
                            16'(time_n),
                            busy_n,
                            r_switch,
                            (32'(done_n) >= 32'(n_use)),
                            fin ? 16'(r_e_resp) : 16'd0,
                            fin ? wait_v[15:0] : 16'd0,
                            fin ? 16'(tat) : 16'd0,
                            fin ? 16'(time_n) : 16'd0,
                            fin ? r_e_id : 8'd0,
                            fin,
                            ran,
                            ran ? r_e_id : 8'd0
                        };
                        r_state <= rrqs_pkg::ST_IDLE;
                    end
                end

                rrqs_pkg::ST_LOAD: begin
                    if (out_free) begin
                        r_out <= {
                            (rrqs_pkg::OUT_BITS - rrqs_pkg::OUT_USED)'(0),
                            16'd0,
                            16'd0,
                            16'd0,
                            (n_use == '0),
                            82'd0
                        };
                        r_state <= rrqs_pkg::ST_IDLE;
                    end
                end

                default: r_state <= rrqs_pkg::ST_IDLE;
            endcase
        end
    end

endmodule
